/* rtl/arc_pkg.sv */
// arc_pkg: shared constants, types and helper functions for the ASCII radix converter.
// Used by arc_ctrl, arc_dp and ascii_radix_converter; depends on nothing.
package arc_pkg;

  // Value and output sizing
  localparam int VALUE_WIDTH    = 64;
  localparam int MAX_OUT_DIGITS = 64;

  // Digit counts of a full-width value in each base
  localparam int BIN_DIGITS = VALUE_WIDTH;
  localparam int OCT_DIGITS = (VALUE_WIDTH + 2) / 3;
  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int DEC_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;

  // Digit work register: wide enough for the BCD form, which is the widest
  localparam int WORK_W  = 4 * DEC_DIGITS;
  localparam int COUNT_W = $clog2(VALUE_WIDTH + 1);

  // Base codes
  typedef enum logic [1:0] {
    BASE_BIN = 2'd0,
    BASE_OCT = 2'd1,
    BASE_DEC = 2'd2,
    BASE_HEX = 2'd3
  } base_t;

  // Register indexes
  localparam logic [1:0] REG_SOURCE_BASE = 2'd0;
  localparam logic [1:0] REG_TARGET_BASE = 2'd1;

  // Controller states
  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_LOAD,
    ST_DABBLE,
    ST_SKIP,
    ST_EMIT
  } arc_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accum;
    logic load;
    logic dabble;
    logic skip;
    logic emit;
  } arc_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_dec;
    logic dabble_last;
    logic skip_more;
    logic rem_one;
    logic out_free;
  } arc_stat_t;

  // Decode an ASCII character to {is_hex_digit, value}
  function automatic logic [4:0] char_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {["0":"9"]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {["A":"F"]}) begin
      r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    end else if (c inside {["a":"f"]}) begin
      r = {1'b1, 4'(c - 8'h61 + 8'd10)};
    end
    return r;
  endfunction

  // Encode a digit value as upper-case ASCII
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = 8'h30 + {4'd0, d};
    end else begin
      r = 8'h41 + {4'd0, d} - 8'd10;
    end
    return r;
  endfunction

endpackage

/* rtl/arc_ctrl.sv */
// arc_ctrl: sequencer for the ASCII radix converter.
// Issues arc_pkg::arc_cmd_t commands to arc_dp and follows its arc_pkg::arc_stat_t status.
module arc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  input  arc_pkg::arc_stat_t stat,
  output arc_pkg::arc_cmd_t  cmd
);

  arc_pkg::arc_state_t state;
  arc_pkg::arc_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arc_pkg::ST_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      arc_pkg::ST_ACCUM: begin
        in_ready  = 1'b1;
        cmd.accum = in_valid;
        if (in_valid && in_last) begin
          state_next = arc_pkg::ST_LOAD;
        end
      end
      arc_pkg::ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = stat.is_dec ? arc_pkg::ST_DABBLE : arc_pkg::ST_SKIP;
      end
      arc_pkg::ST_DABBLE: begin
        cmd.dabble = 1'b1;
        if (stat.dabble_last) begin
          state_next = arc_pkg::ST_SKIP;
        end
      end
      arc_pkg::ST_SKIP: begin
        if (stat.skip_more) begin
          cmd.skip = 1'b1;
        end else begin
          state_next = arc_pkg::ST_EMIT;
        end
      end
      arc_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.rem_one) begin
            state_next = arc_pkg::ST_ACCUM;
          end
        end
      end
      default: begin
        state_next = arc_pkg::ST_ACCUM;
      end
    endcase
  end

endmodule

/* rtl/arc_dp.sv */
// arc_dp: datapath of the ASCII radix converter: base registers, accumulator,
// double-dabble BCD stage, digit shifter and output register. Uses arc_pkg.
module arc_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [1:0]         cfg_data,
  input  logic [7:0]         in_char,
  input  arc_pkg::arc_cmd_t  cmd,
  output arc_pkg::arc_stat_t stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         out_char,
  output logic               out_last,
  output logic               overflow
);

  localparam int VW = arc_pkg::VALUE_WIDTH;
  localparam int WW = arc_pkg::WORK_W;
  localparam int CW = arc_pkg::COUNT_W;

  arc_pkg::base_t       src_base;
  arc_pkg::base_t       tgt_base;
  logic [VW-1:0]        acc;
  logic                 ovf_flag;
  logic                 trunc;
  logic [WW-1:0]        work;
  logic [CW-1:0]        rem;
  logic [CW-1:0]        cnt;

  logic [4:0]           dec_char;
  logic                 digit_ok;
  logic [VW+3:0]        prod;
  logic [VW+3:0]        sum;
  logic [3:0]           top;
  logic [WW-1:0]        work_shift;
  logic [WW-1:0]        work_load;
  logic [CW-1:0]        rem_load;
  logic [WW-1:0]        bcd_adj;
  logic                 out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_base <= arc_pkg::BASE_OCT;
      tgt_base <= arc_pkg::BASE_BIN;
    end else if (cfg_valid) begin
      case (cfg_index)
        arc_pkg::REG_SOURCE_BASE: src_base <= arc_pkg::base_t'(cfg_data);
        arc_pkg::REG_TARGET_BASE: tgt_base <= arc_pkg::base_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // Decode character and form acc * base + digit
  always_comb begin
    dec_char = arc_pkg::char_digit(in_char);
    case (src_base)
      arc_pkg::BASE_BIN: begin
        digit_ok = dec_char[4] && (dec_char[3:0] < 4'd2);
        prod     = {3'b0, acc, 1'b0};
      end
      arc_pkg::BASE_OCT: begin
        digit_ok = dec_char[4] && (dec_char[3:0] < 4'd8);
        prod     = {1'b0, acc, 3'b0};
      end
      arc_pkg::BASE_DEC: begin
        digit_ok = dec_char[4] && (dec_char[3:0] < 4'd10);
        prod     = {1'b0, acc, 3'b0} + {3'b0, acc, 1'b0};
      end
      default: begin
        digit_ok = dec_char[4];
        prod     = {acc, 4'b0};
      end
    endcase
    sum = prod + {{VW{1'b0}}, dec_char[3:0]};
  end

  // Leading digit of the work register and one-digit shift
  always_comb begin
    case (tgt_base)
      arc_pkg::BASE_BIN: begin
        top        = {3'b0, work[WW-1]};
        work_shift = {work[WW-2:0], 1'b0};
      end
      arc_pkg::BASE_OCT: begin
        top        = {1'b0, work[WW-1 -: 3]};
        work_shift = {work[WW-4:0], 3'b0};
      end
      default: begin
        top        = work[WW-1 -: 4];
        work_shift = {work[WW-5:0], 4'b0};
      end
    endcase
  end

  // Left-align the value on a digit boundary for the power-of-two bases; digit count for every base
  always_comb begin
    case (tgt_base)
      arc_pkg::BASE_BIN: begin
        work_load = WW'(acc) << (WW - arc_pkg::BIN_DIGITS);
        rem_load  = CW'(arc_pkg::BIN_DIGITS);
      end
      arc_pkg::BASE_OCT: begin
        work_load = WW'(acc) << (WW - 3 * arc_pkg::OCT_DIGITS);
        rem_load  = CW'(arc_pkg::OCT_DIGITS);
      end
      arc_pkg::BASE_DEC: begin
        work_load = '0;
        rem_load  = CW'(arc_pkg::DEC_DIGITS);
      end
      default: begin
        work_load = WW'(acc) << (WW - 4 * arc_pkg::HEX_DIGITS);
        rem_load  = CW'(arc_pkg::HEX_DIGITS);
      end
    endcase
  end

  // Double-dabble correction: add three to every BCD digit of five or more
  always_comb begin
    for (int i = 0; i < arc_pkg::DEC_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (work[4*i +: 4] >= 4'd5) ? work[4*i +: 4] + 4'd3
                                                   : work[4*i +: 4];
    end
  end

  // Accumulator and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      ovf_flag <= 1'b0;
    end else if (cmd.accum) begin
      if (digit_ok && !ovf_flag) begin
        if (sum[VW+3:VW] != 4'd0) begin
          acc      <= '1;
          ovf_flag <= 1'b1;
        end else begin
          acc <= sum[VW-1:0];
        end
      end
    end else if (cmd.dabble) begin
      acc <= {acc[VW-2:0], 1'b0};
    end else if (cmd.emit && rem == CW'(1)) begin
      acc      <= '0;
      ovf_flag <= 1'b0;
    end
  end

  // Digit work register, digit count and dabble count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work <= work_load;
      rem  <= rem_load;
      cnt  <= CW'(VW);
    end else if (cmd.dabble) begin
      work <= {bcd_adj[WW-2:0], acc[VW-1]};
      cnt  <= cnt - CW'(1);
    end else if (cmd.skip || cmd.emit) begin
      work <= work_shift;
      rem  <= rem - CW'(1);
    end
  end

  // Truncation flag: a non-zero digit dropped above the output limit
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      trunc <= 1'b0;
    end else if (cmd.skip && 32'(rem) > arc_pkg::MAX_OUT_DIGITS && top != 4'd0) begin
      trunc <= 1'b1;
    end
  end

  // Output register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char <= arc_pkg::digit_char(top);
      out_last <= (rem == CW'(1));
      overflow <= ovf_flag || trunc;
    end
  end

  // Status to the controller
  always_comb begin
    stat.is_dec      = (tgt_base == arc_pkg::BASE_DEC);
    stat.dabble_last = (cnt == CW'(1));
    stat.skip_more   = (32'(rem) > arc_pkg::MAX_OUT_DIGITS) ||
                       (rem > CW'(1) && top == 4'd0);
    stat.rem_one     = (rem == CW'(1));
    stat.out_free    = out_free;
  end

`ifndef SYNTHESIS
  // Final digit handed over clears the number state
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && rem == CW'(1)) |=> (acc == '0 && !ovf_flag))
    else $error("accumulator not cleared after final digit");

  // A saturated accumulator reads all ones while characters arrive
  a_saturate: assert property (@(posedge clk) disable iff (rst)
    (cmd.accum && ovf_flag) |-> (acc == '1))
    else $error("overflow set without saturated accumulator");

  // A digit is loaded only when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("digit loaded over a pending beat");

  // Skipping never drops the last remaining digit
  a_skip_keeps_one: assert property (@(posedge clk) disable iff (rst)
    cmd.skip |-> (rem > CW'(1)))
    else $error("skip consumed the final digit");
`endif

endmodule

/* rtl/ascii_radix_converter.sv */
// ascii_radix_converter: one input character per cycle is folded into a 64-bit accumulator.
// After the character marked last: a load step, double-dabble steps when the target is
// decimal, leading-zero skip steps, then an emit step per output digit (held back while
// out_ready is low). No character is taken until the final digit is in the output
// register. Reset: source octal, target binary, accumulator and flags cleared.
// Depends on arc_pkg, arc_ctrl and arc_dp.
module ascii_radix_converter (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [1:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last,
  output logic       overflow
);

  arc_pkg::arc_cmd_t  cmd;
  arc_pkg::arc_stat_t stat;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  arc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  arc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_char   (in_char),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_char  (out_char),
    .out_last  (out_last),
    .overflow  (overflow)
  );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for ascii_radix_converter: streams ASCII numbers through the block
// under every pairing of source and target base and checks each output digit beat.
// Depends on arc_pkg and the ascii_radix_converter RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          SETTLE_CYCLES  = 100;
  localparam int          PHASE_DIGITS   = 10;
  localparam int          HOLD_CYCLES    = 400;
  localparam logic [1:0]  REG_UNUSED     = 2'd2;

  // One output digit beat as the block should present it
  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       ovf;
  } digit_beat_t;

  // Tracks the accumulator and queues the digit beats each number should produce
  class radix_scoreboard;
    logic [63:0]     acc;
    bit              sat;
    arc_pkg::base_t  src_base;
    arc_pkg::base_t  dst_base;
    digit_beat_t     due_q[$];
    int              errors;

    function new();
      acc      = '0;
      sat      = 1'b0;
      src_base = arc_pkg::BASE_OCT;
      dst_base = arc_pkg::BASE_BIN;
      errors   = 0;
    endfunction

    static function int unsigned base_radix(arc_pkg::base_t b);
      case (b)
        arc_pkg::BASE_BIN: return 2;
        arc_pkg::BASE_OCT: return 8;
        arc_pkg::BASE_DEC: return 10;
        default:           return 16;
      endcase
    endfunction

    function void write_reg(logic [1:0] idx, logic [1:0] data);
      if (idx == arc_pkg::REG_SOURCE_BASE) begin
        src_base = arc_pkg::base_t'(data);
      end else if (idx == arc_pkg::REG_TARGET_BASE) begin
        dst_base = arc_pkg::base_t'(data);
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // Fold one accepted character in; on the last one, queue the converted digits
    function void note_char(logic [7:0] c, logic last);
      logic [63:0] r;
      logic [63:0] v;
      logic [63:0] rem;
      logic [63:0] val;
      bit          is_digit;
      logic [7:0]  digs[$];
      digit_beat_t beat;
      is_digit = 1'b1;
      val      = '0;
      r        = 64'(base_radix(src_base));
      if (c >= "0" && c <= "9") begin
        val = 64'(c - 8'h30);
      end else if (c >= "A" && c <= "F") begin
        val = 64'(c - 8'h41 + 8'd10);
      end else if (c >= "a" && c <= "f") begin
        val = 64'(c - 8'h61 + 8'd10);
      end else begin
        is_digit = 1'b0;
      end
      if (is_digit && val < r && !sat) begin
        if (acc > ('1 - val) / r) begin
          acc = '1;
          sat = 1'b1;
        end else begin
          acc = acc * r + val;
        end
      end
      if (!last) return;
      // Peel digits off the low end, most significant ends up at the front
      r = 64'(base_radix(dst_base));
      v = acc;
      do begin
        rem = v % r;
        digs.push_front(rem < 10 ? 8'("0" + rem[7:0]) : 8'("A" + rem[7:0] - 8'd10));
        v = v / r;
      end while (v != 0);
      foreach (digs[k]) begin
        beat.ch   = digs[k];
        beat.last = (k == digs.size() - 1);
        beat.ovf  = sat;
        due_q.push_back(beat);
      end
      acc = '0;
      sat = 1'b0;
    endfunction

    function void check_digit(logic [7:0] ch, logic last, logic ovf);
      digit_beat_t want;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected digit beat char %h last %b overflow %b",
                 $time, ch, last, ovf);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (want.ch !== ch) begin
        $display("%0t: out_char expected %h actual %h", $time, want.ch, ch);
        errors++;
      end
      if (want.last !== last) begin
        $display("%0t: out_last expected %b actual %b", $time, want.last, last);
        errors++;
      end
      if (want.ovf !== ovf) begin
        $display("%0t: overflow expected %b actual %b", $time, want.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [1:0] cfg_data  = '0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] in_char   = '0;
  logic       in_last   = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       out_last;
  logic       overflow;

  radix_scoreboard sb = new();
  int chars_sent   = 0;
  int digits_seen  = 0;
  int idle_cycles  = 0;

  ascii_radix_converter i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_char   (in_char),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_last  (out_last),
    .overflow  (overflow)
  );

  always #5 clk = ~clk;

  // Write one register; keep valid up when another write follows straight on
  task automatic write_reg(logic [1:0] idx, logic [1:0] data, bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    if (!more) cfg_valid <= 1'b0;
  endtask

  // Offer one character beat, idling at random beforehand outside the quiet window
  task automatic offer_char(logic [7:0] c, logic last);
    while (!(chars_sent >= 150 && chars_sent < 200) && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= c;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_char(c, last);
    chars_sent++;
  endtask

  // Drop valid, wait for every queued digit, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] ascii_digit(int unsigned val);
    if (val < 10) return 8'("0" + val);
    return 8'(($urandom_range(1) ? "a" : "A") + val - 10);
  endfunction

  // Random numbers under one base pairing; a few long ones push into saturation
  task automatic random_phase(arc_pkg::base_t src, arc_pkg::base_t dst);
    int          budget;
    int          n;
    int unsigned r;
    int unsigned val;
    bit          long_num;
    bit          noise;
    logic [7:0]  c;
    write_reg(arc_pkg::REG_SOURCE_BASE, src, 1'b1);
    write_reg(arc_pkg::REG_TARGET_BASE, dst, 1'b0);
    r      = radix_scoreboard::base_radix(src);
    budget = 0;
    while (budget < PHASE_DIGITS) begin
      long_num = $urandom_range(99) < 8;
      if (long_num) begin
        case (src)
          arc_pkg::BASE_BIN: n = $urandom_range(64, 66);
          arc_pkg::BASE_OCT: n = $urandom_range(22, 24);
          arc_pkg::BASE_DEC: n = $urandom_range(20, 21);
          default:           n = $urandom_range(16, 17);
        endcase
      end else begin
        n = $urandom_range(1, 9);
      end
      for (int k = 0; k < n; k++) begin
        noise = !(long_num && k == 0) && $urandom_range(99) < 12;
        if (noise) begin
          c = 8'($urandom_range(255));
        end else begin
          if (long_num && k == 0) val = $urandom_range(1, r - 1);
          else if (long_num && $urandom_range(1)) val = r - 1;
          else val = $urandom_range(r - 1);
          c = ascii_digit(val);
        end
        offer_char(c, k == n - 1);
        if (!noise || k == n - 1) budget++;
      end
    end
    settle();
  endtask

  // Stimulus
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // Reset bases: octal in, binary out
    offer_char("1", 1'b0);
    offer_char("7", 1'b1);
    // Empty number, then stray characters around a digit and a non-digit last beat
    offer_char(8'h00, 1'b1);
    offer_char(8'hFF, 1'b0);
    offer_char("8", 1'b0);
    offer_char("3", 1'b0);
    offer_char("x", 1'b1);
    settle();
    write_reg(REG_UNUSED, 2'd3, 1'b1);
    write_reg(arc_pkg::REG_SOURCE_BASE, arc_pkg::BASE_HEX, 1'b1);
    write_reg(arc_pkg::REG_TARGET_BASE, arc_pkg::BASE_DEC, 1'b0);
    offer_char("a", 1'b0);
    offer_char("B", 1'b1);
    // Seventeen hex digits saturate the accumulator
    for (int k = 0; k < 17; k++) begin
      offer_char((k % 2) ? "f" : "F", k == 16);
    end
    settle();
    for (int p = 0; p < 16; p++) begin
      random_phase(arc_pkg::base_t'(2'(p >> 2)), arc_pkg::base_t'(2'(p & 3)));
    end
    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Output side: check each beat, stall at random, hold off once while input is busy
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_digit(out_char, out_last, overflow);
        digits_seen++;
      end
      if (!held && chars_sent >= 80 && out_valid) begin
        hold = HOLD_CYCLES;
        held = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (digits_seen >= 100 && digits_seen < 250) || $urandom_range(99) >= 18;
      end
    end
  end

  // Watchdog: end the run if no beat moves on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("testbench failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

/* sim.f */
rtl/arc_pkg.sv
rtl/arc_ctrl.sv
rtl/arc_dp.sv
rtl/ascii_radix_converter.sv
tb/testbench.sv
